/* hw/rtl/mtdq_pkg.sv */
// Package for the multi-timer deadline queue: sizes, codes and shared types.
// No dependencies; used by every module of the block.
package mtdq_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  // Contents of one timer cell.
  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [63:0] deadline;
    logic [31:0] interval;
    logic        periodic;
    logic [SLOT_W-1:0] slot;
  } cell_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic        write;      // write the add payload into cell_sel
    logic        clear;      // clear the valid bit of cell_sel
    logic        rearm;      // rearm cell_sel at now + interval
    logic [SLOT_W-1:0] cell_sel;
    logic [31:0] id;
    logic [31:0] interval;
    logic        periodic;
    logic [63:0] now;
  } cell_cmd_t;

  // Per-cell flags toward the controller.
  typedef struct packed {
    logic valid;
    logic id_hit;
    logic expired;
  } cell_stat_t;

  // True when a is ahead of b in (deadline, id, slot) order.
  function automatic logic ahead(input cell_t a, input cell_t b);
    logic r;
    if (a.deadline != b.deadline) r = a.deadline < b.deadline;
    else if (a.id != b.id) r = a.id < b.id;
    else r = a.slot < b.slot;
    return r;
  endfunction

endpackage

/* hw/rtl/mtdq_cell.sv */
// One timer cell: holds a slot and passes the best expired candidate down the row.
// Depends on mtdq_pkg.
module mtdq_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [mtdq_pkg::SLOT_W-1:0] my_slot,
  input  mtdq_pkg::cell_cmd_t       cmd,
  input  logic [31:0]               match_id,
  input  logic                      cand_vld_i,
  input  mtdq_pkg::cell_t           cand_i,
  output logic                      cand_vld_o,
  output mtdq_pkg::cell_t           cand_o,
  output mtdq_pkg::cell_stat_t      stat
);
  import mtdq_pkg::*;

  logic        valid_r;
  logic [31:0] id_r;
  logic [63:0] deadline_r;
  logic [31:0] interval_r;
  logic        periodic_r;
  logic        sel;
  cell_t       me;
  logic        cand_vld_r, cand_vld_nxt;
  cell_t       cand_r, cand_nxt;

  assign sel = cmd.cell_sel == my_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel && cmd.write) begin
      valid_r <= 1'b1;
    end else if (sel && cmd.clear) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.write) begin
      id_r <= cmd.id;
      interval_r <= cmd.interval;
      periodic_r <= cmd.periodic;
      deadline_r <= cmd.now + {32'd0, cmd.interval};
    end else if (sel && cmd.rearm) begin
      deadline_r <= cmd.now + {32'd0, interval_r};
    end
  end

  always_comb begin
    me = '{valid: valid_r, id: id_r, deadline: deadline_r, interval: interval_r,
           periodic: periodic_r, slot: my_slot};
    stat.valid = valid_r;
    stat.id_hit = valid_r && (id_r == match_id);
    stat.expired = valid_r && (deadline_r <= cmd.now);
    cand_vld_nxt = cand_vld_i;
    cand_nxt = cand_i;
    if (stat.expired && (!cand_vld_i || ahead(me, cand_i))) begin
      cand_vld_nxt = 1'b1;
      cand_nxt = me;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_vld_r <= 1'b0;
    end else begin
      cand_vld_r <= cand_vld_nxt;
    end
    cand_r <= cand_nxt;
  end

  assign cand_vld_o = cand_vld_r;
  assign cand_o = cand_r;

endmodule

/* hw/rtl/multi_timer_deadline_queue.sv */
// Multi-timer deadline queue top level: command sequencer, output register and cell row.
// Depends on mtdq_pkg and mtdq_cell.
// Add and remove pass through EXEC and SEND before their result is offered.
// A tick runs SCAN, where the best expired candidate passes down the registered cell row,
// then PICK and SEND for each expiry report; after a report that is not the last it scans again.
// One item is in work at a time; the next is taken once all its results have left.
// rst_n (synchronous) frees all timers and clears the time and the id counter.
module multi_timer_deadline_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // command[1:0], interval[33:2], periodic[34], target_id[66:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // kind[1:0], reported_id[33:2], status[34]
  output logic        out_tlast
);
  import mtdq_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_PICK = 6'b001000,
    ST_SEND = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  localparam int WAIT_W = $clog2(SLOTS + 2);

  state_t      state_r, state_nxt;
  logic [1:0]  cmd_r;
  logic [31:0] ival_r, rid_r;
  logic        per_r;
  logic [63:0] now_r;
  logic [31:0] idc_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WAIT_W-1:0] wait_r;
  logic        ov_r;
  logic [1:0]  okind_r;
  logic [31:0] oid_r;
  logic        ost_r, olast_r;

  cell_cmd_t   ccmd;
  cell_stat_t  stat [SLOTS];
  logic        cvld [SLOTS+1];
  cell_t       cand [SLOTS+1];

  logic [SLOT_W-1:0] free_idx, hit_idx;
  logic        any_free, any_hit, more_exp;

  assign cvld[0] = 1'b0;
  assign cand[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    mtdq_cell u_cell (
      .clk(clk), .rst_n(rst_n), .my_slot(SLOT_W'(g)), .cmd(ccmd), .match_id(rid_r),
      .cand_vld_i(cvld[g]), .cand_i(cand[g]), .cand_vld_o(cvld[g+1]),
      .cand_o(cand[g+1]), .stat(stat[g])
    );
  end

  always_comb begin
    any_free = 1'b0;
    any_hit = 1'b0;
    free_idx = '0;
    hit_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!stat[i].valid) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
      if (stat[i].id_hit) begin
        any_hit = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  assign in_tready = state_r == ST_IDLE;
  assign out_tvalid = ov_r;
  assign out_tdata = {5'd0, ost_r, oid_r, okind_r};
  assign out_tlast = olast_r;

  always_comb begin
    ccmd = '0;
    ccmd.now = now_r;
    ccmd.id = idc_r + 32'd1;
    ccmd.periodic = per_r;
    ccmd.interval = (per_r && ival_r == 32'd0) ? 32'd1 : ival_r;
    if (state_r == ST_EXEC && cmd_r == CMD_ADD) begin
      ccmd.write = any_free;
      ccmd.cell_sel = free_idx;
    end else if (state_r == ST_EXEC && cmd_r == CMD_REMOVE) begin
      ccmd.clear = any_hit;
      ccmd.cell_sel = hit_idx;
    end else if (state_r == ST_PICK && cvld[SLOTS]) begin
      ccmd.cell_sel = cand[SLOTS].slot;
      ccmd.rearm = cand[SLOTS].periodic;
      ccmd.clear = !cand[SLOTS].periodic;
    end
  end

  always_comb begin
    more_exp = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (stat[i].expired && !(ccmd.cell_sel == SLOT_W'(i) && (ccmd.clear || ccmd.rearm))) begin
        more_exp = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (cmd_r == CMD_TICK) state_nxt = ST_SCAN;
        else if (cmd_r == CMD_ADD || cmd_r == CMD_REMOVE) state_nxt = ST_SEND;
        else state_nxt = ST_IDLE;
      end
      ST_SCAN: if (wait_r == WAIT_W'(SLOTS)) state_nxt = ST_PICK;
      ST_PICK: state_nxt = cvld[SLOTS] ? ST_SEND : ST_IDLE;
      ST_SEND: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!ov_r || out_tready) state_nxt = olast_r ? ST_IDLE : ST_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      now_r <= '0;
      idc_r <= '0;
      ov_r <= 1'b0;
      cnt_r <= '0;
      wait_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_tready) ov_r <= 1'b0;
      if (state_r == ST_IDLE && in_tvalid) begin
        cmd_r <= in_tdata[1:0];
        ival_r <= in_tdata[33:2];
        per_r <= in_tdata[34];
        rid_r <= in_tdata[66:35];
      end
      wait_r <= (state_r == ST_SCAN) ? wait_r + WAIT_W'(1) : '0;
      if (state_r == ST_EXEC) begin
        cnt_r <= '0;
        if (cmd_r == CMD_TICK) now_r <= now_r + 64'd1;
        if (cmd_r == CMD_ADD) begin
          okind_r <= KIND_ADD;
          oid_r <= any_free ? idc_r + 32'd1 : 32'd0;
          ost_r <= !any_free;
          olast_r <= 1'b1;
          if (any_free) idc_r <= idc_r + 32'd1;
        end else if (cmd_r == CMD_REMOVE) begin
          okind_r <= KIND_REMOVE;
          oid_r <= rid_r;
          ost_r <= !any_hit;
          olast_r <= 1'b1;
        end
      end
      if (state_r == ST_PICK && cvld[SLOTS]) begin
        okind_r <= KIND_EXPIRY;
        oid_r <= cand[SLOTS].id;
        ost_r <= 1'b0;
        cnt_r <= cnt_r + CNT_W'(1);
        olast_r <= !more_exp || (cnt_r == CNT_W'(MAX_RESULTS - 1));
      end
      if (state_r == ST_SEND) ov_r <= 1'b1;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || $past(out_tready) || !$past(out_tvalid))
    else $error("input taken while a result is held");
  a_send_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEND |=> out_tvalid)
    else $error("result register not loaded");
  a_pick_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK && cvld[SLOTS]) |-> cand[SLOTS].deadline <= now_r)
    else $error("unexpired timer picked");

endmodule

/* verif/tb_multi_timer_deadline_queue.sv */
`timescale 1ns / 1ps
// Self-checking testbench for multi_timer_deadline_queue: directed and random add, remove, tick
// and unused items, checked against an in-bench timer table. Depends on mtdq_pkg and the RTL.
module tb_multi_timer_deadline_queue;
  import mtdq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 337;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] interval;
    logic        periodic;
    logic [31:0] target_id;
    bit          drain;
  } timer_cmd_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] id;
    logic        status;
    logic        last;
  } timer_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [71:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic out_tlast;

  multi_timer_deadline_queue u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow timer table.
  bit          tbl_valid [SLOTS];
  logic [31:0] tbl_id [SLOTS];
  logic [63:0] tbl_deadline [SLOTS];
  logic [31:0] tbl_interval [SLOTS];
  bit          tbl_periodic [SLOTS];
  logic [63:0] now_ms = '0;
  logic [31:0] next_id = '0;

  timer_cmd_t   pending_cmds [$];
  timer_event_t expected_events [$];
  timer_cmd_t   cur_cmd;
  int total_cmds = 0;
  int accepted = 0;
  int events_seen = 0;
  int expiries_seen = 0;
  int errors = 0;
  int drains_done = 0;
  int issued_ids = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit quiet;

  assign quiet = accepted > total_cmds - 50;

  function automatic bit sorts_first(int a, int b);
    if (tbl_deadline[a] != tbl_deadline[b]) return tbl_deadline[a] < tbl_deadline[b];
    if (tbl_id[a] != tbl_id[b]) return tbl_id[a] < tbl_id[b];
    return a < b;
  endfunction

  task automatic apply_timer_cmd(input timer_cmd_t c);
    int i;
    int j;
    int best;
    int tmp;
    int n;
    int hits [$];
    logic [31:0] iv;
    i = 0;
    iv = c.interval;
    case (c.cmd)
      CMD_ADD: begin
        while (i < SLOTS && tbl_valid[i]) i++;
        if (i == SLOTS) begin
          expected_events.push_back('{KIND_ADD, 32'd0, 1'b1, 1'b1});
        end else begin
          next_id = next_id + 32'd1;
          if (c.periodic && iv == 0) iv = 32'd1;
          tbl_valid[i] = 1'b1;
          tbl_id[i] = next_id;
          tbl_interval[i] = iv;
          tbl_periodic[i] = c.periodic;
          tbl_deadline[i] = now_ms + {32'd0, iv};
          expected_events.push_back('{KIND_ADD, next_id, 1'b0, 1'b1});
        end
      end
      CMD_REMOVE: begin
        while (i < SLOTS && !(tbl_valid[i] && tbl_id[i] == c.target_id)) i++;
        if (i < SLOTS) tbl_valid[i] = 1'b0;
        expected_events.push_back('{KIND_REMOVE, c.target_id, i == SLOTS, 1'b1});
      end
      CMD_TICK: begin
        now_ms = now_ms + 64'd1;
        for (j = 0; j < SLOTS; j++)
          if (tbl_valid[j] && tbl_deadline[j] <= now_ms) hits.push_back(j);
        for (i = 0; i < hits.size(); i++) begin
          best = i;
          for (j = i + 1; j < hits.size(); j++)
            if (sorts_first(hits[j], hits[best])) best = j;
          tmp = hits[i];
          hits[i] = hits[best];
          hits[best] = tmp;
        end
        n = hits.size() > MAX_RESULTS ? MAX_RESULTS : hits.size();
        for (i = 0; i < n; i++) begin
          j = hits[i];
          expected_events.push_back('{KIND_EXPIRY, tbl_id[j], 1'b0, i == n - 1});
          if (tbl_periodic[j]) tbl_deadline[j] = now_ms + {32'd0, tbl_interval[j]};
          else tbl_valid[j] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_timer_cmd(cur_cmd);
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0 && pending_cmds[0].drain) begin
          in_tvalid <= 1'b0;
          if (expected_events.size() == 0 && !(in_tvalid && in_tready)) begin
            void'(pending_cmds.pop_front());
            drains_done++;
          end
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {5'd0, cur_cmd.target_id, cur_cmd.periodic, cur_cmd.interval, cur_cmd.cmd};
          if (!quiet && $urandom_range(0, 3) == 0) in_gap <= $urandom_range(1, 6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    timer_event_t exp_ev;
    if (rst_n && out_tvalid && out_tready) begin
      events_seen++;
      if (expected_events.size() == 0) begin
        $error("Unexpected result transfer: kind %0d id %0d", out_tdata[1:0], out_tdata[33:2]);
        errors++;
      end else begin
        exp_ev = expected_events.pop_front();
        if (exp_ev.kind == KIND_EXPIRY) expiries_seen++;
        if (out_tdata[1:0] !== exp_ev.kind) begin
          $error("kind: expected %0d, got %0d", exp_ev.kind, out_tdata[1:0]);
          errors++;
        end
        if (out_tdata[33:2] !== exp_ev.id) begin
          $error("reported_id: expected %0d, got %0d", exp_ev.id, out_tdata[33:2]);
          errors++;
        end
        if (out_tdata[34] !== exp_ev.status) begin
          $error("status: expected %0d, got %0d", exp_ev.status, out_tdata[34]);
          errors++;
        end
        if (out_tlast !== exp_ev.last) begin
          $error("last: expected %0d, got %0d", exp_ev.last, out_tlast);
          errors++;
        end
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) out_stall <= $urandom_range(1, 6);
    end
  end

  task automatic queue_cmd(input logic [1:0] cmd, input logic [31:0] iv, input logic per,
                           input logic [31:0] tid);
    pending_cmds.push_back('{cmd, iv, per, tid, 1'b0});
    total_cmds++;
  endtask

  task automatic queue_random_cmd();
    int r;
    logic [31:0] iv;
    logic [31:0] tid;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      case ($urandom_range(0, 9))
        0: iv = $urandom;
        1, 2, 3: iv = $urandom_range(0, 60);
        default: iv = $urandom_range(0, 12);
      endcase
      queue_cmd(CMD_ADD, iv, 1'($urandom_range(0, 1)), $urandom);
      issued_ids++;
    end else if (r < 58) begin
      if ($urandom_range(0, 9) < 7) tid = $urandom_range(0, issued_ids + 2);
      else tid = $urandom;
      queue_cmd(CMD_REMOVE, $urandom, 1'($urandom_range(0, 1)), tid);
    end else if (r < 98) begin
      queue_cmd(CMD_TICK, $urandom, 1'($urandom_range(0, 1)), $urandom);
    end else begin
      queue_cmd(CMD_UNUSED, $urandom, 1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < SLOTS; k++) tbl_valid[k] = 1'b0;
    // Zero intervals, a maximal interval, an ignored command and repeated ticks.
    queue_cmd(CMD_ADD, 32'd0, 1'b0, 32'd0);
    queue_cmd(CMD_ADD, 32'd0, 1'b1, 32'hFFFF_FFFF);
    queue_cmd(CMD_ADD, 32'hFFFF_FFFF, 1'b1, 32'd0);
    queue_cmd(CMD_ADD, 32'd5, 1'b0, 32'd0);
    queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    queue_cmd(CMD_TICK, 32'd0, 1'b0, 32'd0);
    queue_cmd(CMD_TICK, 32'd0, 1'b0, 32'd0);
    queue_cmd(CMD_REMOVE, 32'd0, 1'b0, 32'd4);
    queue_cmd(CMD_REMOVE, 32'd0, 1'b0, 32'd4);
    queue_cmd(CMD_REMOVE, 32'd0, 1'b0, 32'hFFFF_FFFF);
    queue_cmd(CMD_REMOVE, 32'd0, 1'b0, 32'd3);
    // Fill the table until an add is refused, then let many timers expire together.
    for (k = 0; k < SLOTS + 1; k++) queue_cmd(CMD_ADD, 32'd3, k[0], 32'd0);
    for (k = 0; k < 4; k++) queue_cmd(CMD_TICK, 32'd0, 1'b0, 32'd0);
    queue_cmd(CMD_REMOVE, 32'd0, 1'b0, 32'd2);
    issued_ids = 22;
    pending_cmds.push_back('{CMD_TICK, 32'd0, 1'b0, 32'd0, 1'b1});
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      queue_random_cmd();
      if (k == RANDOM_ITEMS / 2)
        pending_cmds.push_back('{CMD_TICK, 32'd0, 1'b0, 32'd0, 1'b1});
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_events.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (expected_events.size() > 0) begin
      $error("%0d expected results never arrived", expected_events.size());
      errors++;
    end
    $display("Sent %0d commands; checked %0d results, %0d of them expiry reports.",
             accepted, events_seen, expiries_seen);
    $display("Drain pauses: %0d, mismatches: %0d.", drains_done, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout: the run did not complete.");
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* multi_timer_deadline_queue.f */
hw/rtl/mtdq_pkg.sv
hw/rtl/mtdq_cell.sv
hw/rtl/multi_timer_deadline_queue.sv
verif/tb_multi_timer_deadline_queue.sv
